FILE: hdl/bstd_pkg.sv
// ----------------------------------------------------------------------------
// bstd_pkg
// Shared widths, register indexes and reset values of the byte-stuffed
// telemetry deframer.
// ----------------------------------------------------------------------------
package bstd_pkg;

    localparam int DATA_W      = 8;
    localparam int IDX_W       = 5;
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_RESULTS = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARKER       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK         = 3'd4;

    // register reset values
    localparam logic              RST_FIXED_MODE   = 1'b0;
    localparam logic [LEN_W-1:0]  RST_FIXED_LENGTH = 6'd9;
    localparam logic [DATA_W-1:0] RST_MARKER       = 8'd126;
    localparam logic [DATA_W-1:0] RST_ESCAPE       = 8'd125;
    localparam logic [DATA_W-1:0] RST_MASK         = 8'd32;

endpackage

FILE: hdl/byte_stuffed_telemetry_deframer.sv
// ----------------------------------------------------------------------------
// byte_stuffed_telemetry_deframer
// Removes marker/escape byte stuffing from a received byte stream, buffers
// each frame and reads it out as one beat per stored byte.
// ----------------------------------------------------------------------------
// Usage: each received byte is taken in one cycle. When a frame completes
// (closing marker in delimited mode, or the set byte count in fixed-length
// mode), the input stalls while the frame buffer is read out: every result
// beat passes through a read state that addresses the buffer memory and a
// load state that moves its registered read data into the output register,
// waiting there while the sink stalls the previous beat. The input
// reopens as soon as the final beat sits in the output register. At most the
// first 32 stored bytes of a frame are sent. The buffer needs no clearing
// after reset; only entries written in the current frame are ever read.
module byte_stuffed_telemetry_deframer #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bstd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bstd_pkg::DATA_W-1:0]      cfg_data,
    // received bytes
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [bstd_pkg::DATA_W-1:0]      rx_byte,
    // frame bytes
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bstd_pkg::DATA_W-1:0]      frame_byte,
    output logic [bstd_pkg::IDX_W-1:0]       byte_index,
    output logic                             last_byte
);

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int CW    = $clog2(BUFFER_DEPTH + 1);
    localparam int EXT_W = (CW > bstd_pkg::LEN_W) ? CW : bstd_pkg::LEN_W;
    localparam int PX_W  = AW + bstd_pkg::IDX_W;

    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(BUFFER_DEPTH);
    localparam logic [EXT_W-1:0] MAXR_EXT  = EXT_W'(bstd_pkg::MAX_RESULTS);
    localparam logic [EXT_W-1:0] ONE_EXT   = EXT_W'(1);

    typedef enum logic [1:0] {
        P_IDLE,
        P_START,
        P_FRAME,
        P_ESC
    } parse_t;

    typedef enum logic [1:0] {
        C_RX,
        C_RD,
        C_LOAD
    } ctl_t;

    // configuration
    logic                          fixed_mode_reg;
    logic [bstd_pkg::LEN_W-1:0]    fixed_len_reg;
    logic [bstd_pkg::DATA_W-1:0]   marker_reg;
    logic [bstd_pkg::DATA_W-1:0]   escape_reg;
    logic [bstd_pkg::DATA_W-1:0]   mask_reg;

    // control
    parse_t                        parse_reg,  parse_next;
    ctl_t                          ctl_reg,    ctl_next;
    logic [CW-1:0]                 count_reg,  count_next;
    logic [AW-1:0]                 rd_ptr_reg, rd_ptr_next;
    logic [bstd_pkg::LEN_W-1:0]    emit_n_reg, emit_n_next;
    logic                          out_valid_reg, out_valid_next;
    logic [bstd_pkg::DATA_W-1:0]   out_byte_reg,  out_byte_next;
    logic [bstd_pkg::IDX_W-1:0]    out_idx_reg,   out_idx_next;
    logic                          out_last_reg,  out_last_next;

    // buffer memory
    logic [bstd_pkg::DATA_W-1:0]   frame_mem [BUFFER_DEPTH];
    logic [bstd_pkg::DATA_W-1:0]   rd_data_reg;
    logic                          wr_en;
    logic [bstd_pkg::DATA_W-1:0]   wr_data;

    logic                          in_beat;
    logic                          emit;
    logic                          store;
    logic [bstd_pkg::DATA_W-1:0]   store_byte;
    logic [EXT_W-1:0]              len_ext;
    logic [EXT_W-1:0]              eff_len;
    logic [EXT_W-1:0]              cnt_ext;
    logic [EXT_W-1:0]              n_ext;
    logic                          slot_free;
    logic                          at_last;
    logic [PX_W-1:0]               ptr_wide;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (ctl_reg == C_RX);
    assign in_beat    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign last_byte  = out_last_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign at_last   = (EXT_W'(rd_ptr_reg) + ONE_EXT) == EXT_W'(emit_n_reg);
    assign ptr_wide  = PX_W'(rd_ptr_reg);

    // fixed length clamped into 1..BUFFER_DEPTH
    always_comb
    begin
        len_ext = EXT_W'(fixed_len_reg);
        if (len_ext == '0)
            eff_len = ONE_EXT;
        else if (len_ext > DEPTH_EXT)
            eff_len = DEPTH_EXT;
        else
            eff_len = len_ext;
    end

    // byte parser
    always_comb
    begin
        parse_next = parse_reg;
        count_next = count_reg;
        store      = 1'b0;
        store_byte = rx_byte;
        emit       = 1'b0;
        unique case (parse_reg)
            P_IDLE:
            begin
                if (rx_byte == marker_reg)
                begin
                    count_next = '0;
                    parse_next = P_START;
                end
            end
            P_START:
            begin
                if (rx_byte == marker_reg)
                begin
                    if (fixed_mode_reg)
                    begin
                        count_next = '0;
                        parse_next = P_FRAME;
                    end
                end
                else if (rx_byte == escape_reg)
                    parse_next = P_ESC;
                else
                begin
                    store      = 1'b1;
                    parse_next = P_FRAME;
                end
            end
            P_FRAME:
            begin
                if (rx_byte == escape_reg)
                    parse_next = P_ESC;
                else if (rx_byte == marker_reg)
                begin
                    if (fixed_mode_reg)
                        count_next = '0;
                    else
                    begin
                        parse_next = P_IDLE;
                        emit       = 1'b1;
                    end
                end
                else
                    store = 1'b1;
            end
            P_ESC:
            begin
                store      = 1'b1;
                store_byte = rx_byte ^ mask_reg;
                parse_next = P_FRAME;
            end
            default:
            begin
                parse_next = P_IDLE;
            end
        endcase

        // drop bytes past the buffer depth, count holds
        wr_en   = 1'b0;
        wr_data = store_byte;
        if (store && (EXT_W'(count_reg) < DEPTH_EXT))
        begin
            wr_en      = in_beat;
            count_next = count_reg + CW'(1);
        end

        cnt_ext = EXT_W'(count_next);
        if (parse_reg != P_IDLE && !emit && fixed_mode_reg && cnt_ext >= eff_len)
        begin
            parse_next = P_IDLE;
            emit       = 1'b1;
        end

        n_ext = (cnt_ext > MAXR_EXT) ? MAXR_EXT : cnt_ext;
    end

    // readout sequencer and output register
    always_comb
    begin
        ctl_next       = ctl_reg;
        rd_ptr_next    = rd_ptr_reg;
        emit_n_next    = emit_n_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        unique case (ctl_reg)
            C_RX:
            begin
                if (in_beat && emit && n_ext != '0)
                begin
                    rd_ptr_next = '0;
                    emit_n_next = bstd_pkg::LEN_W'(n_ext);
                    ctl_next    = C_RD;
                end
            end
            C_RD:
            begin
                ctl_next = C_LOAD;
            end
            C_LOAD:
            begin
                // read data reflects rd_ptr_reg; hold until the slot frees
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    out_idx_next   = ptr_wide[bstd_pkg::IDX_W-1:0];
                    out_last_next  = at_last;
                    if (at_last)
                        ctl_next = C_RX;
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                        ctl_next    = C_RD;
                    end
                end
            end
            default:
            begin
                ctl_next = C_RX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_mode_reg <= bstd_pkg::RST_FIXED_MODE;
            fixed_len_reg  <= bstd_pkg::RST_FIXED_LENGTH;
            marker_reg     <= bstd_pkg::RST_MARKER;
            escape_reg     <= bstd_pkg::RST_ESCAPE;
            mask_reg       <= bstd_pkg::RST_MASK;
            parse_reg      <= P_IDLE;
            ctl_reg        <= C_RX;
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            emit_n_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bstd_pkg::REG_FIXED_MODE:   fixed_mode_reg <= cfg_data[0];
                    bstd_pkg::REG_FIXED_LENGTH:
                        fixed_len_reg <= cfg_data[bstd_pkg::LEN_W-1:0];
                    bstd_pkg::REG_MARKER:       marker_reg <= cfg_data;
                    bstd_pkg::REG_ESCAPE:       escape_reg <= cfg_data;
                    bstd_pkg::REG_MASK:         mask_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_beat)
            begin
                parse_reg <= parse_next;
                count_reg <= count_next;
            end
            ctl_reg       <= ctl_next;
            rd_ptr_reg    <= rd_ptr_next;
            emit_n_reg    <= emit_n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    // input is held during readout, so writes and reads never meet
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[count_reg[AW-1:0]] <= wr_data;
        rd_data_reg <= frame_mem[rd_ptr_reg];
    end

endmodule

FILE: hdl/bstd_checker.sv
// ----------------------------------------------------------------------------
// bstd_checker
// Port-level checks of the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bstd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [bstd_pkg::DATA_W-1:0]      frame_byte,
    input  logic [bstd_pkg::IDX_W-1:0]       byte_index,
    input  logic                             last_byte
);

    logic [bstd_pkg::IDX_W-1:0] exp_idx_reg;

    // track the index the next beat must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
                exp_idx_reg <= last_byte ? '0 : byte_index + bstd_pkg::IDX_W'(1);
        end
    end

    // beats of a frame count up from zero
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_index == exp_idx_reg)
        else $error("byte_index out of sequence");

    // input stays closed while a frame is still being read out
    a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_byte |-> !in_ready)
        else $error("input open during frame readout");

    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({frame_byte, byte_index, last_byte}))
        else $error("result beat carries unknown bits");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte)
            && $stable(byte_index) && $stable(last_byte))
        else $error("result beat changed while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind byte_stuffed_telemetry_deframer bstd_checker u_bstd_checker (.*);
